[hw/rtl/emcs_pkg.sv]
// ----------------------------------------------------------------------------
// Edge-mask component splitter package
// Shared sizes, configuration register indexes, item types and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package emcs_pkg;

    localparam int EDGE_SLOTS   = 64;
    localparam int VERTEX_SLOTS = 64;
    localparam int EIDX_W       = 6;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int MASK_W       = 64;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 4'd1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SPLIT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [EIDX_W-1:0] edge_index;
        logic [VIDX_W-1:0] edge_u;
        logic [VIDX_W-1:0] edge_v;
        logic [MASK_W-1:0] live_edges;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] component_mask;
        logic [5:0]        component_number;
        logic              is_last;
    } out_item_t;

    typedef struct packed {
        logic load_edge;
        logic start_query;
        logic edge_rewind;
        logic edge_step;
        logic emit_ground;
        logic vertex_first;
        logic vertex_step;
        logic walk_begin;
        logic walk_edge;
        logic queue_pop;
        logic cur_from_queue;
        logic emit_walk;
        logic emit_left;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic ground_hit;
        logic edge_last;
        logic vert_visited;
        logic vert_end;
        logic queue_more;
        logic gathered_zero;
        logic out_free;
    } sts_t;

endpackage

[hw/rtl/edge_mask_component_splitter.sv]
// ----------------------------------------------------------------------------
// Edge-mask component splitter
// Splits a mask of live edges into independent components of a graph whose
// edge endpoints are loaded into an on-chip table one edge per item.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_data) takes two kinds of item. A
// load item writes both endpoints of one edge slot. A
// split item starts a query that emits one or more items on the result
// channel (m_valid, m_ready, m_data), the last of them marked by is_last.
// The configuration channel sets the vertex and edge counts and is always
// ready; the user must write it only while no query is running, since the
// block itself does not enforce this. The edge table is scanned one edge
// per cycle for each vertex taken off the walk queue. Input is not taken
// while a query runs.
// The result is held in an output register. When the receiver stalls, the
// query stops at its next result until that register is taken.
// Reset clears the visited marks and masks, sets both counts to 64 and
// empties the output; the edge table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
module edge_mask_component_splitter import emcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    emcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_data.req_type),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    emcs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_split_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_SPLIT) |=> !s_ready)
        else $error("Input was ready right after a split item was taken.");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type == REQ_LOAD) && !m_valid |=> !m_valid)
        else $error("A load item produced a result.");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.component_mask == '0)
            |-> m_data.is_last && (m_data.component_number == '0))
        else $error("An empty component was not the single last result.");

    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_ground, cmd.emit_walk, cmd.emit_left, cmd.emit_empty}))
        else $error("More than one result was emitted in one cycle.");

endmodule

[hw/rtl/emcs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module emcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/emcs_datapath.sv]
// ----------------------------------------------------------------------------
// Component splitter datapath
// Edge tables, vertex queue, visited marks, masks, configuration and the
// output register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module emcs_datapath import emcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  in_item_t              in_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [CNT_W-1:0]  vcount_reg, ecount_reg;
    logic [CNT_W-1:0]  ep_reg, ep_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [VIDX_W-1:0] cur_reg, cur_next;
    logic [5:0]        count_reg, count_next;
    logic [MASK_W-1:0] remaining_reg, remaining_next;
    logic [MASK_W-1:0] gathered_reg, gathered_next;
    logic [VERTEX_SLOTS-1:0] visited_reg, visited_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [CNT_W-1:0]  ne_clamp, nv_clamp;
    logic [MASK_W-1:0] use_mask;
    logic [VIDX_W-1:0] ea, eb, q_rdata, nb;
    logic [EIDX_W-1:0] ep_idx;
    logic [MASK_W-1:0] edge_bit;
    logic              edge_live, ground_hit, touch, push_raw, push, out_free;

    assign ne_clamp = (ecount_reg > CNT_W'(EDGE_SLOTS)) ? CNT_W'(EDGE_SLOTS) : ecount_reg;
    assign nv_clamp = (vcount_reg > CNT_W'(VERTEX_SLOTS)) ? CNT_W'(VERTEX_SLOTS) : vcount_reg;

    always_comb begin
        for (int e = 0; e < MASK_W; e++) begin
            use_mask[e] = (CNT_W'(e) < ne_clamp);
        end
    end

    assign ep_idx     = ep_reg[EIDX_W-1:0];
    assign edge_bit   = MASK_W'(1) << ep_idx;
    assign edge_live  = remaining_reg[ep_idx];
    assign ground_hit = edge_live && (ea == '0) && (eb == '0);
    assign touch      = edge_live && ((ea == cur_reg) || (eb == cur_reg));
    assign nb         = (ea == cur_reg) ? eb : ea;
    assign push_raw   = touch && (nb != '0) && !visited_reg[nb]
                        && (tail_reg < CNT_W'(VERTEX_SLOTS));
    assign push       = cmd.walk_edge && push_raw;
    assign out_free   = !out_valid_reg || m_ready;

    always_comb begin
        ep_next = ep_reg;
        if (cmd.edge_rewind) begin
            ep_next = '0;
        end else if (cmd.edge_step) begin
            ep_next = ep_reg + CNT_W'(1);
        end
    end

    emcs_ram #(.WIDTH(VIDX_W), .DEPTH(EDGE_SLOTS)) u_table_a (
        .aclk  (aclk),
        .we    (cmd.load_edge),
        .waddr (in_data.edge_index),
        .wdata (in_data.edge_u),
        .raddr (ep_next[EIDX_W-1:0]),
        .rdata (ea)
    );

    emcs_ram #(.WIDTH(VIDX_W), .DEPTH(EDGE_SLOTS)) u_table_b (
        .aclk  (aclk),
        .we    (cmd.load_edge),
        .waddr (in_data.edge_index),
        .wdata (in_data.edge_v),
        .raddr (ep_next[EIDX_W-1:0]),
        .rdata (eb)
    );

    emcs_ram #(.WIDTH(VIDX_W), .DEPTH(VERTEX_SLOTS)) u_queue (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail_reg[VIDX_W-1:0]),
        .wdata (nb),
        .raddr (head_reg[VIDX_W-1:0]),
        .rdata (q_rdata)
    );

    always_comb begin
        i_next         = i_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        gathered_next  = gathered_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        if (cmd.start_query) begin
            remaining_next = in_data.live_edges & use_mask;
            visited_next   = '0;
            count_next     = '0;
        end
        if (cmd.vertex_first) begin
            i_next = CNT_W'(1);
        end else if (cmd.vertex_step) begin
            i_next = i_reg + CNT_W'(1);
        end
        if (cmd.walk_begin) begin
            cur_next      = i_reg[VIDX_W-1:0];
            visited_next[i_reg[VIDX_W-1:0]] = 1'b1;
            head_next     = CNT_W'(1);
            tail_next     = CNT_W'(1);
            gathered_next = '0;
        end
        if (cmd.walk_edge && touch) begin
            gathered_next = gathered_reg | edge_bit;
        end
        if (push) begin
            visited_next[nb] = 1'b1;
            tail_next        = tail_reg + CNT_W'(1);
        end
        if (cmd.queue_pop) begin
            head_next = head_reg + CNT_W'(1);
        end
        if (cmd.cur_from_queue) begin
            cur_next = q_rdata;
        end

        if (cmd.emit_ground) begin
            remaining_next = remaining_reg & ~edge_bit;
            out_data_next.component_mask = edge_bit;
            out_data_next.is_last        = ((remaining_reg & ~edge_bit) == '0);
        end else if (cmd.emit_walk) begin
            remaining_next = remaining_reg & ~gathered_reg;
            out_data_next.component_mask = gathered_reg;
            out_data_next.is_last        = ((remaining_reg & ~gathered_reg) == '0);
        end else if (cmd.emit_left) begin
            remaining_next = '0;
            out_data_next.component_mask = remaining_reg;
            out_data_next.is_last        = 1'b1;
        end else if (cmd.emit_empty) begin
            out_data_next.component_mask = '0;
            out_data_next.is_last        = 1'b1;
        end
        if (cmd.emit_ground || cmd.emit_walk || cmd.emit_left || cmd.emit_empty) begin
            out_data_next.component_number = count_reg;
            out_valid_next = 1'b1;
            count_next     = count_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= CNT_W'(VERTEX_SLOTS);
            ecount_reg    <= CNT_W'(EDGE_SLOTS);
            remaining_reg <= '0;
            gathered_reg  <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
            ep_reg        <= '0;
            i_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_valid && (cfg_index == CFG_VERTEX_COUNT)) begin
                vcount_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_EDGE_COUNT)) begin
                ecount_reg <= cfg_data;
            end
            remaining_reg <= remaining_next;
            gathered_reg  <= gathered_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
            ep_reg        <= ep_next;
            i_reg         <= i_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign sts.rem_zero      = (remaining_reg == '0);
    assign sts.ground_hit    = ground_hit;
    assign sts.edge_last     = (ep_reg == (ne_clamp - CNT_W'(1)));
    assign sts.vert_visited  = visited_reg[i_reg[VIDX_W-1:0]];
    assign sts.vert_end      = (i_reg >= nv_clamp);
    assign sts.queue_more    = (head_reg < tail_reg) || push_raw;
    assign sts.gathered_zero = (gathered_reg == '0);
    assign sts.out_free      = out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[hw/rtl/emcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Component splitter controller
// Sequences edge loads, the ground loop scan, the breadth-first walks, the
// leftover and empty results, and holds each result until the output register is free.
// ----------------------------------------------------------------------------
module emcs_ctrl import emcs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic req_type,
    output logic s_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_GSCAN  = 4'd2;
    localparam logic [3:0] ST_VCHECK = 4'd3;
    localparam logic [3:0] ST_WSCAN  = 4'd4;
    localparam logic [3:0] ST_POP    = 4'd5;
    localparam logic [3:0] ST_LOAD   = 4'd6;
    localparam logic [3:0] ST_WEND   = 4'd7;
    localparam logic [3:0] ST_LEFT   = 4'd8;
    localparam logic [3:0] ST_EMPTY  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (req_type == REQ_SPLIT) begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_CHECK;
                    end else begin
                        cmd.load_edge = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (sts.rem_zero) begin
                    state_next = ST_EMPTY;
                end else begin
                    cmd.edge_rewind = 1'b1;
                    state_next      = ST_GSCAN;
                end
            end
            ST_GSCAN: begin
                if (!sts.ground_hit || sts.out_free) begin
                    cmd.emit_ground = sts.ground_hit;
                    if (sts.edge_last) begin
                        cmd.vertex_first = 1'b1;
                        state_next       = ST_VCHECK;
                    end else begin
                        cmd.edge_step = 1'b1;
                    end
                end
            end
            ST_VCHECK: begin
                if (sts.rem_zero) begin
                    state_next = ST_IDLE;
                end else if (sts.vert_end) begin
                    state_next = ST_LEFT;
                end else if (sts.vert_visited) begin
                    cmd.vertex_step = 1'b1;
                end else begin
                    cmd.walk_begin  = 1'b1;
                    cmd.edge_rewind = 1'b1;
                    state_next      = ST_WSCAN;
                end
            end
            ST_WSCAN: begin
                cmd.walk_edge = 1'b1;
                if (sts.edge_last) begin
                    state_next = sts.queue_more ? ST_POP : ST_WEND;
                end else begin
                    cmd.edge_step = 1'b1;
                end
            end
            ST_POP: begin
                cmd.queue_pop = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.cur_from_queue = 1'b1;
                cmd.edge_rewind    = 1'b1;
                state_next         = ST_WSCAN;
            end
            ST_WEND: begin
                if (sts.gathered_zero) begin
                    cmd.vertex_step = 1'b1;
                    state_next      = ST_VCHECK;
                end else if (sts.out_free) begin
                    cmd.emit_walk   = 1'b1;
                    cmd.vertex_step = 1'b1;
                    state_next      = ST_VCHECK;
                end
            end
            ST_LEFT: begin
                if (sts.out_free) begin
                    cmd.emit_left = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (sts.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[test/edge_mask_component_splitter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge-mask component splitter testbench
// Loads edge endpoints, splits live-edge masks and rewrites the vertex and
// edge counts between phases. The sender runs in random bursts and the
// receiver stalls on a rotating pattern. Component items are compared with an
// in-bench breadth-first split of the same table and counts, or with a fixed expected item for directed splits.
// ----------------------------------------------------------------------------
module edge_mask_component_splitter_tb;
    import emcs_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 16;
    localparam int REPORT_CAP  = 40;
    localparam int PHASES      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;
    localparam logic [MASK_W-1:0]    ALL_EDGES = '1;

    typedef enum logic [1:0] {ROW_LOAD, ROW_SPLIT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [EIDX_W-1:0]     slot;
        logic [VIDX_W-1:0]     u;
        logic [VIDX_W-1:0]     v;
        logic [MASK_W-1:0]     live;
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] val;
        bit                    known;
        logic [MASK_W-1:0]     want_mask;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [VIDX_W-1:0] end_a [EDGE_SLOTS];
    logic [VIDX_W-1:0] end_b [EDGE_SLOTS];
    logic [CNT_W-1:0]  verts_in_use;
    logic [CNT_W-1:0]  edges_in_use;
    out_item_t         pending_components [$];
    out_item_t         oldest;
    row_t              plan [$];
    int                cycle;
    int                mismatches;
    int                burst_left;
    logic [15:0]       ready_pat;
    logic [6:0]        ready_age;

    edge_mask_component_splitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                   input logic [MASK_W-1:0] want);
        if (mismatches < REPORT_CAP)
            $display("cycle %0d: %s got %h, want %h", cycle, what, got, want);
        mismatches++;
    endtask

    // Expected components of one split, in the order the block emits them.
    function automatic void split_mask(input logic [MASK_W-1:0] live);
        logic [MASK_W-1:0] rest;
        logic [MASK_W-1:0] grab;
        logic [MASK_W-1:0] one_edge;
        logic [MASK_W-1:0] parts [$];
        bit                marked [VERTEX_SLOTS];
        logic [VIDX_W-1:0] fifo [VERTEX_SLOTS];
        logic [VIDX_W-1:0] cur;
        logic [VIDX_W-1:0] ea;
        logic [VIDX_W-1:0] eb;
        logic [VIDX_W-1:0] far;
        out_item_t         r;
        bit                hit;
        int                ne;
        int                nv;
        int                head;
        int                tail;
        int                e;
        int                vx;

        ne = (edges_in_use > EDGE_SLOTS) ? EDGE_SLOTS : int'(edges_in_use);
        nv = (verts_in_use > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(verts_in_use);
        rest = live;
        if (ne < MASK_W)
            rest &= (64'd1 << ne) - 64'd1;
        foreach (marked[i])
            marked[i] = 1'b0;

        if (rest == '0) begin
            r.component_mask   = '0;
            r.component_number = '0;
            r.is_last          = 1'b1;
            pending_components.push_back(r);
            return;
        end

        for (e = 0; e < ne; e++) begin
            one_edge = 64'd1 << e;
            if ((rest & one_edge) != '0 && end_a[e] == '0 && end_b[e] == '0) begin
                parts.push_back(one_edge);
                rest &= ~one_edge;
            end
        end

        for (vx = 1; vx < nv; vx++) begin
            if (marked[vx])
                continue;
            head = 0;
            tail = 0;
            hit  = 1'b0;
            grab = '0;
            fifo[tail] = VIDX_W'(vx);
            tail++;
            marked[vx] = 1'b1;
            while (head < tail) begin
                cur = fifo[head];
                head++;
                for (e = 0; e < ne; e++) begin
                    one_edge = 64'd1 << e;
                    if ((rest & one_edge) == '0)
                        continue;
                    ea = end_a[e];
                    eb = end_b[e];
                    if (ea != cur && eb != cur)
                        continue;
                    grab |= one_edge;
                    hit = 1'b1;
                    far = (ea == cur) ? eb : ea;
                    if (far != '0 && !marked[far] && tail < VERTEX_SLOTS) begin
                        marked[far] = 1'b1;
                        fifo[tail] = far;
                        tail++;
                    end
                end
            end
            if (hit) begin
                parts.push_back(grab);
                rest &= ~grab;
            end
        end

        if (rest != '0)
            parts.push_back(rest);

        foreach (parts[n]) begin
            r.component_mask   = parts[n];
            r.component_number = 6'(n);
            r.is_last          = (n == parts.size() - 1);
            pending_components.push_back(r);
        end
    endfunction

    function automatic in_item_t random_load(input int span);
        in_item_t item;
        item.req_type   = REQ_LOAD;
        item.edge_index = EIDX_W'($urandom_range(0, EDGE_SLOTS - 1));
        item.live_edges = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin
                item.edge_u = '0;
                item.edge_v = '0;
            end
            1: begin
                item.edge_u = '0;
                item.edge_v = VIDX_W'($urandom_range(1, span));
            end
            2: begin
                item.edge_u = VIDX_W'($urandom);
                item.edge_v = VIDX_W'($urandom);
            end
            default: begin
                item.edge_u = VIDX_W'($urandom_range(1, span));
                item.edge_v = VIDX_W'($urandom_range(1, span));
            end
        endcase
        return item;
    endfunction

    function automatic in_item_t random_split();
        in_item_t          item;
        logic [MASK_W-1:0] r1;
        logic [MASK_W-1:0] r2;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        item.req_type   = REQ_SPLIT;
        item.edge_index = EIDX_W'($urandom);
        item.edge_u     = VIDX_W'($urandom);
        item.edge_v     = VIDX_W'($urandom);
        case ($urandom_range(0, 9))
            0:       item.live_edges = ALL_EDGES;
            1, 2, 3: item.live_edges = r1;
            4, 5:    item.live_edges = r1 & r2;
            6, 7:    item.live_edges = r1 | r2;
            8:       item.live_edges = r1 & r2 & {$urandom, $urandom};
            default: item.live_edges = ($urandom_range(0, 1) == 0) ? '0
                                       : 64'd1 << $urandom_range(0, MASK_W - 1);
        endcase
        return item;
    endfunction

    function automatic void phase_plan(input int p, output int verts, output int edges,
                                       output int items);
        case (p)
            0:       begin verts = 12;  edges = 16;  items = 10; end
            1:       begin verts = 64;  edges = 1;   items = 8;  end
            2:       begin verts = 127; edges = 127; items = 4;  end
            3:       begin verts = 0;   edges = 64;  items = 8;  end
            4:       begin verts = 20;  edges = 24;  items = 10; end
            5:       begin verts = 64;  edges = 64;  items = 4;  end
            6:       begin verts = 1;   edges = 40;  items = 6;  end
            default: begin verts = 6;   edges = 3;   items = 10; end
        endcase
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic feed(input in_item_t item);
        send_item(item);
        if (item.req_type == REQ_LOAD) begin
            end_a[item.edge_index] = item.edge_u;
            end_b[item.edge_index] = item.edge_v;
        end else begin
            split_mask(item.live_edges);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_components.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == CFG_VERTEX_COUNT)
            verts_in_use = val;
        else if (sel == CFG_EDGE_COUNT)
            edges_in_use = val;
    endtask

    task automatic plan_load(input logic [EIDX_W-1:0] slot, input logic [VIDX_W-1:0] u,
                             input logic [VIDX_W-1:0] v);
        row_t row;
        row = '{ROW_LOAD, slot, u, v, ALL_EDGES, '0, '0, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic plan_split(input logic [MASK_W-1:0] live, input bit known,
                              input logic [MASK_W-1:0] want_mask);
        row_t row;
        row = '{ROW_SPLIT, '1, '1, '1, live, '0, '0, known, want_mask};
        plan.push_back(row);
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] sel,
                            input logic [CFG_DATA_W-1:0] val);
        row_t row;
        row = '{ROW_CFG, '0, '0, '0, '0, sel, val, 1'b0, '0};
        plan.push_back(row);
    endtask

    always @(posedge aclk) begin
        ready_age <= ready_age + 7'd1;
        if (ready_age == 7'd0) begin
            case ($urandom_range(0, 3))
                0:       ready_pat <= 16'hFFFF;
                1:       ready_pat <= 16'($urandom) | 16'h0001;
                2:       ready_pat <= 16'h00FF;
                default: ready_pat <= 16'hA5A5;
            endcase
        end else begin
            ready_pat <= {ready_pat[0], ready_pat[15:1]};
        end
        m_ready <= ready_pat[0];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_components.size() == 0) begin
                report_mismatch("component item with none pending", m_data.component_mask,
                                '0);
            end else begin
                oldest = pending_components.pop_front();
                if (m_data.component_mask !== oldest.component_mask)
                    report_mismatch("component_mask", m_data.component_mask,
                                    oldest.component_mask);
                if (m_data.component_number !== oldest.component_number)
                    report_mismatch("component_number", 64'(m_data.component_number),
                                    64'(oldest.component_number));
                if (m_data.is_last !== oldest.is_last)
                    report_mismatch("is_last", 64'(m_data.is_last), 64'(oldest.is_last));
            end
        end
    end

    initial begin
        cycle = 0;
        while (cycle < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        in_item_t  item;
        row_t      row;
        out_item_t typed;
        int        verts;
        int        edges;
        int        items;
        int        span;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        m_ready   <= 1'b0;
        ready_pat <= 16'hFFFF;
        ready_age <= '0;
        burst_left   = 0;
        mismatches   = 0;
        verts_in_use = 7'd64;
        edges_in_use = 7'd64;

        // Queries here use four table slots at most, all loaded before use.
        plan_split('0, 1'b1, '0);
        plan_cfg(CFG_EDGE_COUNT, 7'd4);
        plan_cfg(CFG_VERTEX_COUNT, 7'd8);
        plan_load(6'd0, 6'd0, 6'd0);
        plan_load(6'd1, 6'd1, 6'd2);
        plan_load(6'd2, 6'd3, 6'd2);
        plan_load(6'd3, 6'd5, 6'd63);
        plan_load(6'd63, 6'd63, 6'd63);
        plan_split(ALL_EDGES, 1'b0, '0);
        plan_split(64'h1, 1'b1, 64'h1);
        plan_split(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '0);
        plan_split(64'h6, 1'b0, '0);
        plan_cfg(CFG_VERTEX_COUNT, 7'd0);
        plan_split(64'hF, 1'b0, '0);
        plan_cfg(CFG_VERTEX_COUNT, 7'd3);
        plan_split(64'hF, 1'b0, '0);
        plan_cfg(CFG_SPARE, 7'd127);
        plan_split(64'hA, 1'b0, '0);
        plan_cfg(CFG_EDGE_COUNT, 7'd0);
        plan_split(ALL_EDGES, 1'b1, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[n]) begin
            row = plan[n];
            item.req_type   = (row.kind == ROW_LOAD) ? REQ_LOAD : REQ_SPLIT;
            item.edge_index = row.slot;
            item.edge_u     = row.u;
            item.edge_v     = row.v;
            item.live_edges = row.live;
            case (row.kind)
                ROW_CFG: begin
                    drain();
                    write_reg(row.sel, row.val);
                end
                ROW_SPLIT: begin
                    if (row.known) begin
                        send_item(item);
                        typed.component_mask   = row.want_mask;
                        typed.component_number = '0;
                        typed.is_last          = 1'b1;
                        pending_components.push_back(typed);
                    end else begin
                        feed(item);
                    end
                end
                default: feed(item);
            endcase
        end

        // Every slot is written before any query reaches beyond slot 3.
        for (int slot = 0; slot < EDGE_SLOTS; slot++) begin
            item = random_load(15);
            item.edge_index = EIDX_W'(slot);
            feed(item);
        end

        for (int p = 0; p < PHASES; p++) begin
            phase_plan(p, verts, edges, items);
            drain();
            write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(verts));
            drain();
            write_reg(CFG_EDGE_COUNT, CFG_DATA_W'(edges));
            span = (verts > VERTEX_SLOTS) ? VERTEX_SLOTS - 1 : ((verts < 2) ? 1 : verts - 1);
            repeat (items) begin
                if ($urandom_range(0, 11) == 0)
                    drain();
                if ($urandom_range(0, 9) < 3)
                    feed(random_load(span));
                else
                    feed(random_split());
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
